// File: rtl/core/tav_pkg.sv
// ----------------------------------------------------------------------------
// Tilt axis vector rotator package
// Shared constants and types: sine polynomial coefficients, the sine unit
// latency and the status word of the item queue.
// ----------------------------------------------------------------------------
package tav_pkg;

    // Q30 unity and a quarter turn in 32-bit phase.
    localparam logic [31:0] Q30_ONE      = 32'h4000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // Odd Taylor coefficients of sin(pi/2*u) in Q30.
    localparam logic [31:0] SIN_C1 = 32'd1686629713;
    localparam logic [31:0] SIN_C3 = 32'd693598671;
    localparam logic [31:0] SIN_C5 = 32'd85569306;
    localparam logic [31:0] SIN_C7 = 32'd5026995;
    localparam logic [31:0] SIN_C9 = 32'd172272;

    // Register stages from phase to sine value.
    localparam int SINE_LAT = 7;

    // Queue occupancy flags.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: rtl/core/tav_front.sv
// ----------------------------------------------------------------------------
// Tilt axis vector rotator front end
// Holds the tilt register, accepts items, turns angles into phases and
// classifies each item by the zero test on the tilt before it is queued.
// ----------------------------------------------------------------------------
module tav_front #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16,
    parameter int ITEM_W      = 3 * COORD_WIDTH + 65
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic signed [COORD_WIDTH-1:0] i_coord_z,
    input  logic signed [ANGLE_WIDTH-1:0] i_tilt_angle,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic signed [ANGLE_WIDTH-1:0] i_cfg_data,
    input  tav_pkg::t_q_status            i_q_status,
    output logic                          o_push,
    output logic [ITEM_W-1:0]             o_item
);
    import tav_pkg::*;

    logic [ANGLE_WIDTH-1:0] r_tilt;
    logic                   r_valid;
    logic [ITEM_W-1:0]      r_item;
    logic [ITEM_W-1:0]      n_item;
    logic                   take;
    logic [31:0]            phase_t;
    logic [31:0]            phase_a;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_valid && i_q_status.full;
    assign o_push      = r_valid && !i_q_status.full;
    assign take        = i_in_valid && !o_in_stall;
    assign o_item      = r_item;

    assign phase_t = {i_tilt_angle, {(32 - ANGLE_WIDTH){1'b0}}};
    assign phase_a = {r_tilt, {(32 - ANGLE_WIDTH){1'b0}}};
    assign n_item  = {i_coord_x, i_coord_y, i_coord_z, phase_t, phase_a,
                      (r_tilt == '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_tilt <= i_cfg_data;
            end
            if (take) begin
                r_valid <= 1'b1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

endmodule

// File: rtl/core/tav_queue.sv
// ----------------------------------------------------------------------------
// Tilt axis vector rotator item queue
// Two-entry queue that lets the front end and the back end stall apart.
// ----------------------------------------------------------------------------
module tav_queue #(
    parameter int WIDTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output tav_pkg::t_q_status o_status
);
    import tav_pkg::*;

    logic [WIDTH-1:0] r_mem [2];
    logic [1:0]       r_cnt;
    logic             r_wr;
    logic             r_rd;

    assign o_data         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == 2'd2);
    assign o_status.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/core/tav_sine.sv
// ----------------------------------------------------------------------------
// Tilt axis vector rotator sine unit
// Pipelined sine of a 32-bit phase: quadrant fold, then the odd Taylor
// polynomial in Horner form, one multiplication per stage, result in Q30.
// ----------------------------------------------------------------------------
module tav_sine (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_phase,
    output logic signed [31:0] o_sine
);
    import tav_pkg::*;

    function automatic logic [31:0] mul_q30(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b} + (64'd1 << 29);
        return p[61:30];
    endfunction

    logic [31:0] r_u   [6];
    logic        r_neg [6];
    logic [31:0] r_sq  [4];
    logic [31:0] r_acc [4];
    logic [31:0] r_s;
    logic        r_sneg;
    logic [31:0] s_raw;
    logic [31:0] s_clamp;

    assign s_raw   = mul_q30(r_acc[3], r_u[5]);
    assign s_clamp = (s_raw > Q30_ONE) ? Q30_ONE : s_raw;
    assign o_sine  = r_sneg ? -$signed(r_s) : $signed(r_s);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Fold the phase into the first quadrant.
            r_u[0]   <= i_phase[30] ? (Q30_ONE - {2'b00, i_phase[29:0]})
                                    : {2'b00, i_phase[29:0]};
            r_neg[0] <= i_phase[31];
            for (int i = 1; i < 6; i++) begin
                r_u[i]   <= r_u[i-1];
                r_neg[i] <= r_neg[i-1];
            end
            r_sq[0] <= mul_q30(r_u[0], r_u[0]);
            for (int i = 1; i < 4; i++) begin
                r_sq[i] <= r_sq[i-1];
            end
            r_acc[0] <= SIN_C7 - mul_q30(SIN_C9, r_sq[0]);
            r_acc[1] <= SIN_C5 - mul_q30(r_acc[0], r_sq[1]);
            r_acc[2] <= SIN_C3 - mul_q30(r_acc[1], r_sq[2]);
            r_acc[3] <= SIN_C1 - mul_q30(r_acc[2], r_sq[3]);
            r_s      <= s_clamp;
            r_sneg   <= r_neg[5];
        end
    end

endmodule

// File: rtl/core/tav_back.sv
// ----------------------------------------------------------------------------
// Tilt axis vector rotator back end
// Pops queued items, computes the four sines, builds the rotation matrix for
// the item's branch and applies it with rounding and saturation.
// ----------------------------------------------------------------------------
module tav_back #(
    parameter int COORD_WIDTH = 32,
    parameter int ITEM_W      = 3 * COORD_WIDTH + 65
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ITEM_W-1:0]             i_item,
    input  tav_pkg::t_q_status            i_q_status,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [COORD_WIDTH-1:0] o_rot_x,
    output logic signed [COORD_WIDTH-1:0] o_rot_y,
    output logic signed [COORD_WIDTH-1:0] o_rot_z
);
    import tav_pkg::*;

    localparam int CF  = ((60 - COORD_WIDTH) > 30) ? 30 : (60 - COORD_WIDTH);
    localparam int SH  = 30 - CF;
    localparam int EW  = CF + 2;
    localparam int PW  = EW + COORD_WIDTH;
    localparam int SW  = PW + 2;
    localparam int RW  = SW + 2;
    localparam int DW  = 3 * COORD_WIDTH + 1;
    localparam logic signed [RW-1:0] MAXV = {{(RW - COORD_WIDTH + 1){1'b0}},
                                             {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [RW-1:0] MINV = ~MAXV;

    function automatic logic signed [31:0] q30m(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + (64'sd1 <<< 29);
        return p[61:30];
    endfunction

    function automatic logic signed [EW-1:0] coef(input logic signed [31:0] x);
        logic signed [33:0] w;
        w = (34'(x) <<< 1) + (34'sd1 <<< SH);
        w = w >>> (SH + 1);
        return w[EW-1:0];
    endfunction

    logic                 adv;
    logic [31:0]          q_pt;
    logic [31:0]          q_pa;
    logic [DW-1:0]        q_data;
    logic signed [31:0]   st, ct, sa, ca;

    logic                 r_dv  [SINE_LAT];
    logic [DW-1:0]        r_dly [SINE_LAT];

    // Product stage.
    logic                 r_v0;
    logic [DW-1:0]        r_d0;
    logic signed [31:0]   r_st, r_ct, r_sa, r_ca, r_ssa, r_sact, r_stca, r_cact;
    // Matrix stage.
    logic                 r_v1;
    logic [DW-1:0]        r_d1;
    logic signed [31:0]   m_q30 [9];
    logic signed [EW-1:0] r_e   [9];
    // Multiply stage.
    logic                 r_v2;
    logic signed [PW-1:0] r_p   [9];
    logic signed [COORD_WIDTH-1:0] vec [3];
    // Sum stage.
    logic                 r_v3;
    logic signed [SW-1:0] r_s   [3];
    // Output stage.
    logic                 r_out_valid;
    logic signed [COORD_WIDTH-1:0] r_rot [3];
    logic signed [COORD_WIDTH-1:0] n_rot [3];

    assign adv         = !r_out_valid || !i_out_stall;
    assign o_pop       = adv && !i_q_status.empty;
    assign q_pt        = i_item[64:33];
    assign q_pa        = i_item[32:1];
    assign q_data      = {i_item[ITEM_W-1:65], i_item[0]};
    assign o_out_valid = r_out_valid;
    assign o_rot_x     = r_rot[0];
    assign o_rot_y     = r_rot[1];
    assign o_rot_z     = r_rot[2];

    tav_sine u_sin_t (.i_clk(i_clk), .i_en(adv), .i_phase(q_pt), .o_sine(st));
    tav_sine u_cos_t (.i_clk(i_clk), .i_en(adv), .i_phase(q_pt + QUARTER_TURN),
                      .o_sine(ct));
    tav_sine u_sin_a (.i_clk(i_clk), .i_en(adv), .i_phase(q_pa), .o_sine(sa));
    tav_sine u_cos_a (.i_clk(i_clk), .i_en(adv), .i_phase(q_pa + QUARTER_TURN),
                      .o_sine(ca));

    // The branch flag is taken from the product stage so that it travels with
    // the sines and products it selects between.
    always_comb begin
        if (r_d0[0]) begin
            // Plain turn about y.
            m_q30[0] = r_ct;  m_q30[1] = '0;      m_q30[2] = -r_st;
            m_q30[3] = '0;    m_q30[4] = Q30_ONE; m_q30[5] = '0;
            m_q30[6] = r_st;  m_q30[7] = '0;      m_q30[8] = r_ct;
        end else begin
            // Tilt about x followed by the turn about the tilted axis.
            m_q30[0] = r_ct;    m_q30[1] = '0;    m_q30[2] = r_st;
            m_q30[3] = -r_ssa;  m_q30[4] = r_ca;  m_q30[5] = r_sact;
            m_q30[6] = -r_stca; m_q30[7] = -r_sa; m_q30[8] = r_cact;
        end
    end

    assign vec[0] = r_d1[DW-1 -: COORD_WIDTH];
    assign vec[1] = r_d1[DW-1-COORD_WIDTH -: COORD_WIDTH];
    assign vec[2] = r_d1[COORD_WIDTH:1];

    always_comb begin
        logic signed [RW-1:0] w;
        for (int i = 0; i < 3; i++) begin
            w = (RW'(r_s[i]) <<< 1) + (RW'(1) <<< CF);
            w = w >>> (CF + 1);
            if (w > MAXV) begin
                n_rot[i] = MAXV[COORD_WIDTH-1:0];
            end else if (w < MINV) begin
                n_rot[i] = MINV[COORD_WIDTH-1:0];
            end else begin
                n_rot[i] = w[COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SINE_LAT; i++) begin
                r_dv[i] <= 1'b0;
            end
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_dv[0] <= o_pop;
            for (int i = 1; i < SINE_LAT; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
            r_v0        <= r_dv[SINE_LAT-1];
            r_v1        <= r_v0;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_out_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dly[0] <= q_data;
            for (int i = 1; i < SINE_LAT; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
            r_d0   <= r_dly[SINE_LAT-1];
            r_st   <= st;
            r_ct   <= ct;
            r_sa   <= sa;
            r_ca   <= ca;
            r_ssa  <= q30m(st, sa);
            r_sact <= q30m(sa, ct);
            r_stca <= q30m(st, ca);
            r_cact <= q30m(ca, ct);
            r_d1   <= r_d0;
            for (int i = 0; i < 9; i++) begin
                r_e[i] <= coef(m_q30[i]);
            end
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_p[3*r+c] <= PW'(r_e[3*r+c]) * PW'(vec[c]);
                end
            end
            for (int r = 0; r < 3; r++) begin
                r_s[r] <= SW'(r_p[3*r]) + SW'(r_p[3*r+1]) + SW'(r_p[3*r+2]);
            end
            for (int i = 0; i < 3; i++) begin
                r_rot[i] <= n_rot[i];
            end
        end
    end

endmodule

// File: rtl/core/tilt_axis_vector_rotator.sv
// ----------------------------------------------------------------------------
// Tilt axis vector rotator
// Rotates a fixed-point 3D vector by a tilt angle about an axis set by the
// configured x-axis tilt, or about the y axis when that tilt is zero.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output stall is low; the back end
// pipeline moves one stage per cycle and holds as a whole while a result
// waits on the output stall.
// Reset: synchronous, active low; clears the tilt register, the queue and
// every valid flag. No clearing pass, items are taken right after reset.
module tilt_axis_vector_rotator #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic signed [COORD_WIDTH-1:0] i_coord_z,
    input  logic signed [ANGLE_WIDTH-1:0] i_tilt_angle,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic signed [ANGLE_WIDTH-1:0] i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [COORD_WIDTH-1:0] o_rot_x,
    output logic signed [COORD_WIDTH-1:0] o_rot_y,
    output logic signed [COORD_WIDTH-1:0] o_rot_z
);
    import tav_pkg::*;

    // An item carries three coordinates, two 32-bit phases and the branch flag.
    localparam int ITEM_W = 3 * COORD_WIDTH + 65;

    logic              q_push;
    logic              q_pop;
    logic [ITEM_W-1:0] f_item;
    logic [ITEM_W-1:0] q_item;
    t_q_status         q_status;

    // The front end registers each accepted item, converts its angles to
    // phases and marks whether the zero-tilt branch applies.
    tav_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .ITEM_W      (ITEM_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_z    (i_coord_z),
        .i_tilt_angle (i_tilt_angle),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_q_status   (q_status),
        .o_push       (q_push),
        .o_item       (f_item)
    );

    // A two-entry queue decouples the front end from the back end stall.
    tav_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (f_item),
        .i_pop    (q_pop),
        .o_data   (q_item),
        .o_status (q_status)
    );

    // The back end computes the sines, the matrix and the rotated vector.
    tav_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .ITEM_W      (ITEM_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (q_item),
        .i_q_status  (q_status),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rot_x     (o_rot_x),
        .o_rot_y     (o_rot_y),
        .o_rot_z     (o_rot_z)
    );

    // The front end never pushes into a full queue.
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> !q_push)
        else $error("item pushed into a full queue");

    // The back end never pops an empty queue.
    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.empty |-> !q_pop)
        else $error("item popped from an empty queue");

    // Input stall is raised only while the queue is full.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> q_status.full)
        else $error("input stalled with room in the queue");

    // Reset leaves no result pending.
    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule
